// File: hdl/serial_pin_command_shell_unit_assert.svh
// Assertion macros for the serial pin command shell.
// The macros sample on clk and are disabled while rst_n is low.
`ifndef SERIAL_PIN_COMMAND_SHELL_UNIT_ASSERT_SVH
`define SERIAL_PIN_COMMAND_SHELL_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The condition holds at every rising clock edge.
`define SPCS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// The consequent holds whenever the antecedent holds.
`define SPCS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define SPCS_ASSERT_ALWAYS(lbl, cond)
`define SPCS_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// File: hdl/spcs_pkg.sv
package spcs_pkg;

  // Line length limit and counter width.
  localparam int LINE_MAX = 32;
  localparam int CNT_W    = 6;
  localparam int PINS     = 48;

  // Command queue geometry.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Status codes.
  localparam logic [2:0] ST_READ_OK  = 3'd0;
  localparam logic [2:0] ST_WRITE_OK = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_BAD_PORT = 3'd3;
  localparam logic [2:0] ST_BAD_PIN  = 3'd4;
  localparam logic [2:0] ST_BAD_VAL  = 3'd5;
  localparam logic [2:0] ST_BAD_CMD  = 3'd6;
  localparam logic [2:0] ST_LOST     = 3'd7;

  // Character codes.
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic            lost;
    logic            run;
    logic            echo;
    logic [7:0]      ch;
    logic            ge3;
    logic            ge4;
    logic [3:0][7:0] head;
    logic [PINS-1:0] levels;
  } cmd_t;

  // Queue fill status.
  typedef struct packed {
    logic [QCNT_W-1:0] cnt;
    logic              full;
    logic              empty;
  } qstat_t;

endpackage

// File: hdl/serial_pin_command_shell_unit.sv
// Serial pin command shell.
// Input channel in_*: one item per received event. in_tuser is the event kind
// (0 character, 1 link lost); in_tdata carries the received byte and the
// current levels of the 48 pins. Every accepted item yields exactly one result
// item on out_*: the echo (out_tuser set when the character was stored), the
// line outcome (out_tlast set when a line was executed or discarded), status,
// offending character, read level and the pin direction and drive bits after
// the item.
// Throughput is one item per cycle while the receiver takes results. The
// classify stage writes the two-entry command queue when an item is accepted,
// and the execute stage then loads the output register from the queue.
// When the receiver stalls, the output register holds and the queue fills;
// in_tready drops once both queue entries are taken.
// Synchronous reset clears the character count, the queue, the output valid
// and all pins to inputs driven low.
`include "serial_pin_command_shell_unit_assert.svh"

module serial_pin_command_shell_unit
  import spcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // rx_char[7:0], pin_levels[55:8]
  input  logic         in_tuser,   // kind[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // echo_char[7:0], status[10:8], bad_char[18:11], read_value[19],
  // pin_direction[67:20], pin_drive[115:68], zero[119:116]
  output logic [119:0] out_tdata,
  output logic         out_tuser,  // echo_valid[0]
  output logic         out_tlast   // line_done
);

  cmd_t            push_cmd, pop_cmd;
  qstat_t          qs;
  logic            push, pop;
  logic [7:0]      echo_char, bad_char;
  logic [2:0]      status;
  logic            read_value;
  logic [PINS-1:0] pin_direction, pin_drive;

  spcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .kind       (in_tuser),
    .rx_char    (in_tdata[7:0]),
    .pin_levels (in_tdata[55:8]),
    .q_full     (qs.full),
    .in_ready   (in_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  spcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (qs)
  );

  spcs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (pop_cmd),
    .q_empty       (qs.empty),
    .out_ready     (out_tready),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .echo_valid    (out_tuser),
    .echo_char     (echo_char),
    .line_done     (out_tlast),
    .status        (status),
    .bad_char      (bad_char),
    .read_value    (read_value),
    .pin_direction (pin_direction),
    .pin_drive     (pin_drive)
  );

  assign out_tdata = {4'h0, pin_drive, pin_direction, read_value, bad_char,
                      status, echo_char};

  // Checks on queue flow and result coding.
  `SPCS_ASSERT_IMPLY(a_ready_has_room, in_tready, !qs.full)
  `SPCS_ASSERT_IMPLY(a_pop_not_empty, pop, !qs.empty)
  `SPCS_ASSERT_IMPLY(a_idle_status, out_tvalid && !out_tlast, (status == ST_READ_OK) && (bad_char == 8'h00))
  `SPCS_ASSERT_IMPLY(a_lost_no_echo, out_tvalid && (status == ST_LOST), out_tlast && !out_tuser)

endmodule

// File: hdl/spcs_front.sv
module spcs_front
  import spcs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            kind,
  input  logic [7:0]      rx_char,
  input  logic [PINS-1:0] pin_levels,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output cmd_t            push_cmd
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, cnt_eff;
  logic [3:0][7:0]  head_r, head_nxt;
  logic             is_eol, is_print, at_max, fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign push     = fire;

  // Classify the character and work out the next line state.
  always_comb begin
    is_eol   = (rx_char == CH_CR) || (rx_char == CH_NL);
    is_print = (rx_char >= CH_SPACE) && (rx_char <= CH_TILDE);
    cnt_inc  = cnt_r + CNT_W'(1);
    at_max   = cnt_inc >= CNT_W'(LINE_MAX);
    head_nxt = head_r;
    if (!kind && is_print && (cnt_r < CNT_W'(4))) begin
      head_nxt[cnt_r[1:0]] = rx_char;
    end
    if (kind || is_eol) begin
      cnt_nxt = '0;
    end else if (is_print) begin
      cnt_nxt = at_max ? '0 : cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
    cnt_eff = is_print ? cnt_inc : cnt_r;
  end

  // Build the queued command.
  always_comb begin
    push_cmd.lost   = kind;
    push_cmd.echo   = !kind && is_print;
    push_cmd.run    = !kind && (is_eol || (is_print && at_max));
    push_cmd.ch     = rx_char;
    push_cmd.ge3    = cnt_eff >= CNT_W'(3);
    push_cmd.ge4    = cnt_eff >= CNT_W'(4);
    push_cmd.head   = head_nxt;
    push_cmd.levels = pin_levels;
  end

  // Character count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Head characters of the line; read only after the line wrote them.
  always_ff @(posedge clk) begin
    if (fire) begin
      head_r <= head_nxt;
    end
  end

endmodule

// File: hdl/spcs_queue.sv
module spcs_queue
  import spcs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   pop_cmd,
  output qstat_t stat
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign pop_cmd    = mem_r[rd_ptr_r];
  assign stat.cnt   = cnt_r;
  assign stat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign stat.empty = cnt_r == '0;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/spcs_back.sv
module spcs_back
  import spcs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  input  logic            q_empty,
  input  logic            out_ready,
  output logic            pop,
  output logic            out_valid,
  output logic            echo_valid,
  output logic [7:0]      echo_char,
  output logic            line_done,
  output logic [2:0]      status,
  output logic [7:0]      bad_char,
  output logic            read_value,
  output logic [PINS-1:0] pin_direction,
  output logic [PINS-1:0] pin_drive
);

  logic [PINS-1:0] dir_r, drv_r, dir_nxt, drv_nxt, mask;
  logic            out_valid_r;
  logic [2:0]      st, port;
  logic [7:0]      bad, c0, c1, c2, c3;
  logic            rv, port_ok, pin_ok;
  logic [5:0]      bidx;

  assign pop       = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // Parse and execute the line.
  always_comb begin
    c0      = cmd.head[0];
    c1      = cmd.head[1];
    c2      = cmd.head[2];
    c3      = cmd.head[3];
    port_ok = ((c0 >= CH_UP_A) && (c0 <= CH_UP_F)) ||
              ((c0 >= CH_LOW_A) && (c0 <= CH_LOW_F));
    pin_ok  = (c1 >= CH_ZERO) && (c1 <= CH_SEVEN);
    // Both letter ranges start at a code whose low bits are one.
    port    = c0[2:0] - 3'd1;
    bidx    = {port, c1[2:0]};
    mask    = PINS'(1) << bidx;
    st      = ST_READ_OK;
    bad     = '0;
    rv      = 1'b0;
    dir_nxt = dir_r;
    drv_nxt = drv_r;
    if (cmd.lost) begin
      st = ST_LOST;
    end else if (cmd.run) begin
      if (!cmd.ge3) begin
        st = ST_SHORT;
      end else if (!port_ok) begin
        st  = ST_BAD_PORT;
        bad = c0;
      end else if (!pin_ok) begin
        st  = ST_BAD_PIN;
        bad = c1;
      end else if (c2 == CH_QUEST) begin
        dir_nxt = dir_r & ~mask;
        rv      = cmd.levels[bidx];
        st      = ST_READ_OK;
      end else if (cmd.ge4 && (c2 == CH_EQUAL)) begin
        if ((c3 == CH_ZERO) || (c3 == CH_ONE)) begin
          dir_nxt = dir_r | mask;
          drv_nxt = (c3 == CH_ONE) ? (drv_r | mask) : (drv_r & ~mask);
          st      = ST_WRITE_OK;
        end else begin
          st  = ST_BAD_VAL;
          bad = c3;
        end
      end else begin
        st  = ST_BAD_CMD;
        bad = c0;
      end
    end
  end

  // Pin state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= '0;
      drv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        dir_r <= dir_nxt;
        drv_r <= drv_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      echo_valid    <= cmd.echo;
      echo_char     <= cmd.echo ? cmd.ch : 8'h00;
      line_done     <= cmd.lost || cmd.run;
      status        <= st;
      bad_char      <= bad;
      read_value    <= rv;
      pin_direction <= dir_nxt;
      pin_drive     <= drv_nxt;
    end
  end

endmodule
